[rtl/cosine_similarity_stream_core_defines.svh]
// assertion macros shared by the cosine similarity core
`ifndef COSINE_SIMILARITY_STREAM_CORE_DEFINES_SVH
`define COSINE_SIMILARITY_STREAM_CORE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define CSIM_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("csim check failed");

// next-cycle implication, checked out of reset
`define CSIM_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("csim check failed");

`endif

[rtl/csim_pkg.sv]
// types and constants of the cosine similarity core
package csim_pkg;
    localparam int ELEM_W     = 16;
    localparam int DOT_W      = 44;
    localparam int SQ_W       = 43;
    localparam int PROD_W     = 2 * SQ_W;
    localparam int ROOT_W     = SQ_W;
    localparam int REM_W      = ROOT_W + 2;
    localparam int HALF_W     = (SQ_W + 1) / 2;
    localparam int QUO_W      = 15;
    localparam int SIM_W      = 16;
    localparam int STEP_W     = 6;
    localparam int MUL_STEPS  = 4;
    localparam int SQRT_STEPS = ROOT_W;
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = 2;
    localparam int Q_CW       = 3;

    typedef struct packed {
        logic signed [DOT_W-1:0] dot;
        logic [SQ_W-1:0]         sa;
        logic [SQ_W-1:0]         sb;
    } csim_sums_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_SQRT,
        ST_CHK,
        ST_DIV,
        ST_DONE
    } csim_state_t;
endpackage

[rtl/csim_front.sv]
// front end: product stage and saturating running sums
module csim_front
    import csim_pkg::*;
(
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic signed [ELEM_W-1:0] elem_a,
    input  logic signed [ELEM_W-1:0] elem_b,
    input  logic                     s_tlast,
    input  logic [Q_CW-1:0]          q_level,
    output logic                     push,
    output csim_sums_t               push_sums
);
    localparam int PW = 2 * ELEM_W;

    logic                 p1_valid_reg, p1_valid_next;
    logic                 p1_last_reg;
    logic signed [PW-1:0] pd_reg, qa_reg, qb_reg;
    logic signed [DOT_W-1:0] dot_reg, dot_next;
    logic [SQ_W-1:0]      sa_reg, sa_next, sb_reg, sb_next;
    logic signed [DOT_W:0] dot_sum;
    logic [SQ_W:0]        sa_sum, sb_sum;
    logic                 accept;
    logic signed [DOT_W-1:0] dot_sat;
    logic [SQ_W-1:0]      sa_sat, sb_sat;

    // keep a slot free for a last word still in the product stage
    assign s_tready = ({1'b0, q_level} + {3'b0, p1_valid_reg & p1_last_reg}) < Q_DEPTH;
    assign accept   = s_tvalid & s_tready;
    assign p1_valid_next = accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            p1_valid_reg <= 1'b0;
        end else begin
            p1_valid_reg <= p1_valid_next;
        end
        if (accept) begin
            p1_last_reg <= s_tlast;
            pd_reg <= PW'(elem_a * elem_b);
            qa_reg <= PW'(elem_a * elem_a);
            qb_reg <= PW'(elem_b * elem_b);
        end
    end

    always_comb begin
        dot_sum = (DOT_W+1)'(dot_reg) + (DOT_W+1)'(pd_reg);
        sa_sum  = {1'b0, sa_reg} + (SQ_W+1)'(unsigned'(qa_reg));
        sb_sum  = {1'b0, sb_reg} + (SQ_W+1)'(unsigned'(qb_reg));
        if (dot_sum[DOT_W] != dot_sum[DOT_W-1]) begin
            dot_sat = dot_sum[DOT_W] ? {1'b1, {(DOT_W-1){1'b0}}} : {1'b0, {(DOT_W-1){1'b1}}};
        end else begin
            dot_sat = dot_sum[DOT_W-1:0];
        end
        sa_sat = sa_sum[SQ_W] ? {SQ_W{1'b1}} : sa_sum[SQ_W-1:0];
        sb_sat = sb_sum[SQ_W] ? {SQ_W{1'b1}} : sb_sum[SQ_W-1:0];

        push = p1_valid_reg & p1_last_reg;
        push_sums.dot = dot_sat;
        push_sums.sa  = sa_sat;
        push_sums.sb  = sb_sat;

        dot_next = dot_reg;
        sa_next  = sa_reg;
        sb_next  = sb_reg;
        if (p1_valid_reg) begin
            if (p1_last_reg) begin
                dot_next = '0;
                sa_next  = '0;
                sb_next  = '0;
            end else begin
                dot_next = dot_sat;
                sa_next  = sa_sat;
                sb_next  = sb_sat;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dot_reg <= '0;
            sa_reg  <= '0;
            sb_reg  <= '0;
        end else begin
            dot_reg <= dot_next;
            sa_reg  <= sa_next;
            sb_reg  <= sb_next;
        end
    end
endmodule

[rtl/csim_queue.sv]
// small fifo of finished sums between front and back end
module csim_queue
    import csim_pkg::*;
(
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  csim_sums_t      push_sums,
    input  logic            pop,
    output logic            not_empty,
    output csim_sums_t      head,
    output logic [Q_CW-1:0] level
);
    csim_sums_t          mem_reg [Q_DEPTH];
    logic [Q_AW-1:0]     wr_reg, wr_next, rd_reg, rd_next;
    logic [Q_CW-1:0]     cnt_reg, cnt_next;

    assign not_empty = cnt_reg != '0;
    assign head      = mem_reg[rd_reg];
    assign level     = cnt_reg;

    always_comb begin
        wr_next  = push ? wr_reg + 1'b1 : wr_reg;
        rd_next  = pop ? rd_reg + 1'b1 : rd_reg;
        cnt_next = cnt_reg + Q_CW'(push) - Q_CW'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
        if (push) begin
            mem_reg[wr_reg] <= push_sums;
        end
    end
endmodule

[rtl/csim_back.sv]
// back end: product, square root, division and output register
module csim_back
    import csim_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    q_not_empty,
    input  csim_sums_t              q_head,
    output logic                    pop,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic signed [SIM_W-1:0] similarity,
    output logic                    zero_vector
);
    csim_state_t state_reg, state_next;
    logic [STEP_W-1:0]  step_reg, step_next;
    logic [DOT_W-1:0]   mag_reg, mag_next;
    logic               neg_reg, neg_next;
    logic [SQ_W-1:0]    sa_reg, sa_next, sb_reg, sb_next;
    logic [PROD_W-1:0]  prod_reg, prod_next;
    logic [REM_W-1:0]   rem_reg, rem_next;
    logic [ROOT_W-1:0]  root_reg, root_next;
    logic [QUO_W-1:0]   quo_reg, quo_next;
    logic [SIM_W-1:0]   res_reg, res_next;
    logic               rzero_reg, rzero_next;
    logic               ov_reg, ov_next;
    logic [SIM_W-1:0]   osim_reg, osim_next;
    logic               ozero_reg, ozero_next;

    logic [HALF_W-1:0]   a_part, b_part;
    logic [2*HALF_W-1:0] pp;
    logic [PROD_W-1:0]   pp_sh;
    logic [REM_W+1:0]    rem_sh, trial;
    logic [REM_W-1:0]    r2;
    logic                last_step, out_free, zero_in;

    assign out_free  = !ov_reg || m_tready;
    assign zero_in   = (q_head.sa == '0) || (q_head.sb == '0);
    assign m_tvalid  = ov_reg;
    assign similarity  = osim_reg;
    assign zero_vector = ozero_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (q_not_empty) state_next = zero_in ? ST_DONE : ST_MUL;
            ST_MUL:  if (last_step) state_next = ST_SQRT;
            ST_SQRT: if (last_step) state_next = ST_CHK;
            ST_CHK:  state_next = ({1'b0, mag_reg} >= {2'b0, root_reg}) ? ST_DONE : ST_DIV;
            ST_DIV:  if (last_step) state_next = ST_DONE;
            ST_DONE: if (out_free) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb begin
        pop = 1'b0;
        step_next = step_reg + 1'b1;
        mag_next = mag_reg; neg_next = neg_reg;
        sa_next = sa_reg; sb_next = sb_reg;
        prod_next = prod_reg; rem_next = rem_reg; root_next = root_reg;
        quo_next = quo_reg; res_next = res_reg; rzero_next = rzero_reg;
        ov_next = ov_reg && !m_tready;
        osim_next = osim_reg; ozero_next = ozero_reg;
        last_step = 1'b0;

        // 22 x 22 partial products of the sum halves, accumulated in prod_reg
        a_part = step_reg[1] ? HALF_W'(sa_reg[SQ_W-1:HALF_W]) : sa_reg[HALF_W-1:0];
        b_part = step_reg[0] ? HALF_W'(sb_reg[SQ_W-1:HALF_W]) : sb_reg[HALF_W-1:0];
        pp     = a_part * b_part;
        pp_sh  = PROD_W'(pp) << ((step_reg[1] ? HALF_W : 0) + (step_reg[0] ? HALF_W : 0));
        // one root bit per cycle
        rem_sh = {rem_reg, prod_reg[PROD_W-1 -: 2]};
        trial  = {2'b0, root_reg, 2'b01};
        // one quotient bit per cycle
        r2     = {rem_reg[REM_W-2:0], 1'b0};

        unique case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (q_not_empty) begin
                    pop = 1'b1;
                    neg_next = q_head.dot < 0;
                    mag_next = (q_head.dot < 0) ? DOT_W'(-q_head.dot) : DOT_W'(q_head.dot);
                    sa_next = q_head.sa;
                    sb_next = q_head.sb;
                    prod_next = '0;
                    rem_next = '0;
                    root_next = '0;
                    rzero_next = zero_in;
                    res_next = '0;
                end
            end
            ST_MUL: begin
                prod_next = prod_reg + pp_sh;
                last_step = step_reg == STEP_W'(MUL_STEPS - 1);
                if (last_step) step_next = '0;
            end
            ST_SQRT: begin
                prod_next = {prod_reg[PROD_W-3:0], 2'b00};
                if (rem_sh >= trial) begin
                    rem_next  = REM_W'(rem_sh - trial);
                    root_next = {root_reg[ROOT_W-2:0], 1'b1};
                end else begin
                    rem_next  = REM_W'(rem_sh);
                    root_next = {root_reg[ROOT_W-2:0], 1'b0};
                end
                last_step = step_reg == STEP_W'(SQRT_STEPS - 1);
            end
            ST_CHK: begin
                step_next = '0;
                rem_next  = REM_W'(mag_reg);
                quo_next  = '0;
                // quotient of 2^15 or more saturates
                res_next  = neg_reg ? {1'b1, {(SIM_W-1){1'b0}}} : {1'b0, {(SIM_W-1){1'b1}}};
            end
            ST_DIV: begin
                if (r2 >= {2'b0, root_reg}) begin
                    rem_next = r2 - {2'b0, root_reg};
                    quo_next = {quo_reg[QUO_W-2:0], 1'b1};
                end else begin
                    rem_next = r2;
                    quo_next = {quo_reg[QUO_W-2:0], 1'b0};
                end
                last_step = step_reg == STEP_W'(QUO_W - 1);
                if (last_step) begin
                    res_next = neg_reg ? SIM_W'(-{1'b0, quo_next}) : {1'b0, quo_next};
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    ov_next = 1'b1;
                    osim_next = res_reg;
                    ozero_next = rzero_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ov_reg    <= 1'b0;
        end else begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
        step_reg <= step_next;
        mag_reg <= mag_next; neg_reg <= neg_next;
        sa_reg <= sa_next; sb_reg <= sb_next;
        prod_reg <= prod_next; rem_reg <= rem_next; root_reg <= root_next;
        quo_reg <= quo_next; res_reg <= res_next; rzero_reg <= rzero_next;
        osim_reg <= osim_next; ozero_reg <= ozero_next;
    end
endmodule

[rtl/cosine_similarity_stream_core.sv]
// top level of the streaming cosine similarity core
// usage:
//  s_ channel carries one element pair per word: tdata[15:0] elem_a,
//  tdata[31:16] elem_b, tlast marks the final pair of the vectors.
//  m_ channel gives one word per vector pair: tdata similarity in Q1.15,
//  tuser the zero-magnitude flag.
//  the front end accepts one word per cycle while s_tready is high and
//  keeps saturating sums; finished sums go into a four-entry queue.
//  the back end takes one vector pair at a time through partial products,
//  a bit-serial square root, a check and a restoring division; a zero
//  vector goes straight to the output register.
//  vectors of 65 or more words stream at one word per cycle unless m_ stalls;
//  shorter ones are limited by the back end and the queue depth.
//  a stalled m_ side holds the output word; the back end then waits,
//  the queue fills and s_tready drops.
//  reset clears the sums, queue and output valid at once
module cosine_similarity_stream_core
    import csim_pkg::*;
(
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [2*ELEM_W-1:0]     s_tdata,  // elem_a, elem_b
    input  logic                    s_tlast,
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [SIM_W-1:0]        m_tdata,  // similarity
    output logic                    m_tuser   // zero_vector
);
`include "cosine_similarity_stream_core_defines.svh"

    logic            push, pop, q_not_empty;
    csim_sums_t      push_sums, q_head;
    logic [Q_CW-1:0] q_level;
    logic signed [SIM_W-1:0] sim;

    csim_front u_front (
        .aclk, .aresetn, .s_tvalid, .s_tready,
        .elem_a(s_tdata[ELEM_W-1:0]), .elem_b(s_tdata[2*ELEM_W-1:ELEM_W]),
        .s_tlast, .q_level, .push, .push_sums
    );

    csim_queue u_queue (
        .aclk, .aresetn, .push, .push_sums, .pop,
        .not_empty(q_not_empty), .head(q_head), .level(q_level)
    );

    csim_back u_back (
        .aclk, .aresetn, .q_not_empty, .q_head, .pop,
        .m_tvalid, .m_tready, .similarity(sim), .zero_vector(m_tuser)
    );

    assign m_tdata = sim;

    `CSIM_ASSERT_NOW(a_no_overflow, push && !pop, q_level != Q_CW'(Q_DEPTH))
    `CSIM_ASSERT_NOW(a_zero_result, m_tvalid && m_tuser, m_tdata == '0)
    `CSIM_ASSERT_NEXT(a_pop_empty, q_level == '0 && !push, !pop || push)
endmodule
